@@ hw/rtl/dsfr_pkg.sv @@
`default_nettype none

package dsfr_pkg;

    // Input item kinds carried in the slave-side tuser.
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_TICK = 2'd0;
    localparam t_cmd CMD_EDGE = 2'd1;
    localparam t_cmd CMD_LOAD = 2'd2;

    // Result kinds carried in the master-side tuser.
    typedef logic t_kind;
    localparam t_kind KIND_TX     = 1'b0;
    localparam t_kind KIND_REPORT = 1'b1;

    localparam logic [7:0]  NO_COMMAND   = 8'hFF;
    localparam logic [15:0] TICK_MAX     = 16'hFFFF;
    localparam logic [15:0] GAP_RESET    = 16'd10;
    localparam logic [1:0]  SEND_MAX     = 2'd3;
    localparam int          INJECT_SLOT  = 16;
    localparam int          SKIP_SLOTS   = 8;
    localparam logic [1:0]  COUNTER_MARK = 2'b11;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    // One accepted input item.
    typedef struct packed {
        t_cmd       cmd;
        logic       data_bit;
        logic [7:0] command_byte;
    } t_item;

    // One result item.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] tx_byte;
        logic       minus_flag;
        logic [3:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
        logic [3:0] tape_mode;
        logic       read_only;
    } t_result;

    // Two BCD digits to binary: tens * 10 + units, tens up to 15.
    function automatic logic [7:0] bcd_value(input logic [7:0] v);
        logic [7:0] tens;
        logic [7:0] units;
        tens  = {4'd0, v[7:4]};
        units = {4'd0, v[3:0]};
        return (tens << 3) + (tens << 1) + units;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/deck_status_frame_receiver.sv @@
// An input item passes through the input register and then the result register to the
// master side. Throughput: one input item per cycle while no result stalls; each item is
// decoded in a single pass between the two registers, by an engine that also holds state.
// A stalled result holds the input register, so the input side then stops taking items.
// Reset (synchronous, active low) clears the frame store, counters, pending command
// and previous frame, and sets the frame gap register to 10 ticks.
`default_nettype none

module deck_status_frame_receiver
    import dsfr_pkg::*;
#(
    parameter int FRAME_BYTES = 8,
    parameter int STORE_BITS  = 64,
    parameter int FRAME_BITS  = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write channel: frame_gap_ticks.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [15:0]           i_cfg_data,
    // Input stream.
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,  // data_bit, command_byte, zero fill
    input  wire logic [1:0]            i_s_tuser,  // cmd
    // Result stream.
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,  // tx_byte, minus_flag, hours, minutes,
                                                   // seconds, tape_mode, read_only, zero fill
    output logic                       o_m_tuser   // kind
);

    logic [15:0] r_gap;
    logic        r_out_valid;
    t_result     r_out;

    t_item       in_item;
    t_item       head_item;
    logic        head_valid;
    logic        advance;
    logic        fire;
    logic        res_valid;
    t_result     result;

    // Configuration register; always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= GAP_RESET;
        end else if (i_cfg_valid) begin
            r_gap <= i_cfg_data;
        end
    end

    // Unpack the input transfer.
    assign in_item.cmd          = i_s_tuser;
    assign in_item.data_bit     = i_s_tdata[0];
    assign in_item.command_byte = i_s_tdata[8:1];

    // The head item moves on when the result register is free or draining.
    assign advance = !r_out_valid || i_m_tready;
    assign fire    = head_valid && advance;

    dsfr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (head_valid),
        .o_item    (head_item)
    );

    dsfr_engine #(
        .FRAME_BYTES (FRAME_BYTES),
        .STORE_BITS  (STORE_BITS),
        .FRAME_BITS  (FRAME_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (head_item),
        .i_gap       (r_gap),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= res_valid;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {6'd0, r_out.read_only, r_out.tape_mode, r_out.seconds,
                         r_out.minutes, r_out.hours, r_out.minus_flag, r_out.tx_byte};

endmodule

`default_nettype wire

@@ hw/rtl/dsfr_in_reg.sv @@
`default_nettype none

module dsfr_in_reg
    import dsfr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    input  wire logic  i_advance,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    // The stage takes a new transfer when empty or when its item moves on.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ hw/rtl/dsfr_engine.sv @@
`default_nettype none

module dsfr_engine
    import dsfr_pkg::*;
#(
    parameter int FRAME_BYTES = 8,
    parameter int STORE_BITS  = 64,
    parameter int FRAME_BITS  = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire t_item       i_item,
    input  wire logic [15:0] i_gap,
    output logic             o_res_valid,
    output t_result          o_result
);

    localparam int POS_W   = $clog2(STORE_BITS + 1);
    localparam int FRAME_W = FRAME_BYTES * 8;

    logic [STORE_BITS-1:0] r_store;
    logic [POS_W-1:0]      r_pos;
    logic [15:0]           r_ticks;
    logic [7:0]            r_pending;
    logic [1:0]            r_sends;
    logic [FRAME_W-1:0]    r_prev;

    logic [STORE_BITS-1:0] n_store;
    logic [POS_W-1:0]      n_pos;
    logic [15:0]           n_ticks;
    logic [7:0]            n_pending;
    logic [1:0]            n_sends;
    logic [FRAME_W-1:0]    n_prev;

    logic                  restart;
    logic [POS_W-1:0]      pos_eff;
    logic                  store_wr;
    logic [POS_W-1:0]      pos_next;
    logic [1:0]            sends_inc;
    logic [FRAME_W-1:0]    frame;
    logic [7:0]            cur_byte [FRAME_BYTES];

    // Frame restart test and store write slot.
    assign restart  = r_ticks > i_gap;
    assign pos_eff  = restart ? '0 : r_pos;
    assign store_wr = (i_item.cmd == CMD_EDGE) && (32'(pos_eff) < STORE_BITS);
    assign pos_next = store_wr ? pos_eff + POS_W'(1) : pos_eff;
    assign sends_inc = (r_sends != SEND_MAX) ? r_sends + 2'd1 : r_sends;

    // Store with the new bit written in.
    always_comb begin
        for (int k = 0; k < STORE_BITS; k++) begin
            n_store[k] = (store_wr && (pos_eff == POS_W'(k))) ? i_item.data_bit : r_store[k];
        end
    end

    // Frame view of the updated store; bits past the store read as zero.
    genvar gj, gi, gb;
    generate
        for (gj = 0; gj < FRAME_W; gj++) begin : g_frame
            if (gj < STORE_BITS) begin : g_in
                assign frame[gj] = n_store[gj];
            end else begin : g_out
                assign frame[gj] = 1'b0;
            end
        end
        // The first bit received in each byte is its most significant bit.
        for (gi = 0; gi < FRAME_BYTES; gi++) begin : g_byte
            for (gb = 0; gb < 8; gb++) begin : g_bit
                assign cur_byte[gi][7-gb] = frame[gi*8 + gb];
            end
        end
    endgenerate

    // Next state and result for the item at the head of the input register.
    always_comb begin
        n_pos       = r_pos;
        n_ticks     = r_ticks;
        n_pending   = r_pending;
        n_sends     = r_sends;
        n_prev      = r_prev;
        o_res_valid = 1'b0;
        o_result    = '0;
        case (i_item.cmd)
            CMD_TICK: begin
                if (r_ticks != TICK_MAX) begin
                    n_ticks = r_ticks + 16'd1;
                end
            end
            CMD_LOAD: begin
                n_pending = i_item.command_byte;
                n_sends   = 2'd0;
            end
            CMD_EDGE: begin
                if (restart) begin
                    n_ticks = '0;
                end
                n_pos = pos_next;
                if ((pos_next == POS_W'(INJECT_SLOT)) && (r_pending != NO_COMMAND)) begin
                    // Command injection: send it and skip its byte slots.
                    o_res_valid      = 1'b1;
                    o_result.kind    = KIND_TX;
                    o_result.tx_byte = r_pending;
                    n_sends          = sends_inc;
                    if (sends_inc > 2'd2) begin
                        n_pending = NO_COMMAND;
                    end
                    n_pos = pos_next + POS_W'(SKIP_SLOTS);
                end else if ((32'(pos_next) >= FRAME_BITS) && (frame != r_prev)) begin
                    // A changed full frame; only counter frames are reported.
                    n_prev = frame;
                    if (cur_byte[0][1:0] == COUNTER_MARK) begin
                        o_res_valid         = 1'b1;
                        o_result.kind       = KIND_REPORT;
                        o_result.minus_flag = cur_byte[4][4];
                        o_result.hours      = cur_byte[4][3:0];
                        o_result.minutes    = bcd_value(cur_byte[5]);
                        o_result.seconds    = bcd_value(cur_byte[6]);
                        o_result.tape_mode  = cur_byte[3][3:0];
                        o_result.read_only  = cur_byte[3][7];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // State registers, updated only when an item is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store   <= '0;
            r_pos     <= '0;
            r_ticks   <= '0;
            r_pending <= NO_COMMAND;
            r_sends   <= '0;
            r_prev    <= '0;
        end else if (i_fire) begin
            if (i_item.cmd == CMD_EDGE) begin
                r_store <= n_store;
            end
            r_pos     <= n_pos;
            r_ticks   <= n_ticks;
            r_pending <= n_pending;
            r_sends   <= n_sends;
            r_prev    <= n_prev;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dsfr_checker.sv @@
`default_nettype none

module dsfr_checker
    import dsfr_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_m_tvalid,
    input wire logic                  i_m_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_tdata,
    input wire logic                  o_m_tuser
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("result changed while stalled");

    // A transmit result carries only the command byte.
    a_tx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == KIND_TX)) |-> (o_m_tdata[OUT_DATA_W-1:8] == '0))
        else $error("transmit result has report fields set");

    // A report carries no command byte, and decoded minutes and seconds stay in range.
    a_report_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == KIND_REPORT)) |->
        ((o_m_tdata[7:0] == 8'd0) && (o_m_tdata[20:13] <= 8'd165)
         && (o_m_tdata[28:21] <= 8'd165) && (o_m_tdata[39:34] == 6'd0)))
        else $error("report result malformed");

    // No result right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind deck_status_frame_receiver dsfr_checker u_dsfr_checker (.*);

`default_nettype wire
